// ----- src/ilir_pkg.sv -----
// Shared types and codes for the indexed list block.
package ilir_pkg;

  // Request action codes; codes 6 and 7 are unused and change nothing
  typedef enum logic [2:0] {
    ACT_INS_AT    = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_INS_END   = 3'd2,
    ACT_READ      = 3'd3,
    ACT_REMOVE    = 3'd4,
    ACT_CLEAR     = 3'd5
  } act_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Memory read address select
  typedef enum logic [1:0] {
    RA_TGT   = 2'd0,
    RA_BELOW = 2'd1,
    RA_ABOVE = 2'd2
  } raddr_e;

  // Controller to datapath commands
  typedef struct packed {
    logic   load;          // latch a new request
    logic   ram_re;        // issue a memory read
    raddr_e ra_sel;        // read address: target, index-1 or index+1
    logic   ram_we;        // write the memory
    logic   wa_idx;        // write address: index (1) or target (0)
    logic   wd_mem;        // write data: read data (1) or request value (0)
    logic   idx_load;      // load the shift index
    logic   idx_from_tgt;  // load it from target (1) or count (0)
    logic   idx_dec;
    logic   idx_inc;
    logic   cap_rv;        // capture read data as the result value
    logic   cnt_inc;
    logic   cnt_dec;
    logic   cnt_clr;
  } ilir_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_ins;
    logic is_clr;
    logic is_read;
    logic is_rem;
    logic refused;   // request was refused at load (range or full)
    logic ins_more;  // entries left to move up
    logic rem_more;  // entries left to move down
  } ilir_stat_t;

endpackage

// ----- src/ilir_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ilir_dp.sv -----
// Datapath: request registers, count, shift index, entry memory and result registers.
module ilir_dp #(
  parameter int DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                action_i,
  input  logic [4:0]                position_i,
  input  logic signed [31:0]        item_value_i,
  input  ilir_pkg::ilir_cmd_t       cmd_i,
  output ilir_pkg::ilir_stat_t      stat_o,
  output logic signed [31:0]        read_value_o,
  output logic [1:0]                status_o,
  output logic [4:0]                item_count_o,
  output logic                      is_empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic [2:0]         act_q;
  logic [CW-1:0]      tgt_q;
  logic [31:0]        val_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      idx_q;
  logic [31:0]        rv_q;
  logic [1:0]         st_q;

  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic               ld_ins;
  logic               ld_range;
  logic               ld_full;
  logic [1:0]         ld_st;
  logic [CW-1:0]      ld_tgt;

  logic [AW-1:0]      ram_raddr;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;

  // Range and full checks against the count at transfer time
  assign pos_w  = PW'(position_i);
  assign cnt_w  = PW'(cnt_q);
  assign ld_ins = (action_i == ilir_pkg::ACT_INS_AT) ||
                  (action_i == ilir_pkg::ACT_INS_FRONT) ||
                  (action_i == ilir_pkg::ACT_INS_END);

  always_comb begin
    ld_range = 1'b0;
    if (action_i == ilir_pkg::ACT_INS_AT) begin
      ld_range = pos_w > cnt_w;
    end else if ((action_i == ilir_pkg::ACT_READ) || (action_i == ilir_pkg::ACT_REMOVE)) begin
      ld_range = pos_w >= cnt_w;
    end
  end

  assign ld_full = ld_ins && (cnt_q == CW'(DEPTH));
  assign ld_st   = ld_range ? ilir_pkg::ST_RANGE :
                   (ld_full ? ilir_pkg::ST_FULL : ilir_pkg::ST_OK);

  // Effective target index
  always_comb begin
    case (action_i)
      ilir_pkg::ACT_INS_FRONT: ld_tgt = '0;
      ilir_pkg::ACT_INS_END:   ld_tgt = cnt_q;
      default:                 ld_tgt = CW'(position_i);
    endcase
  end

  // Request and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      tgt_q <= ld_tgt;
      val_q <= item_value_i;
      st_q  <= ld_st;
      rv_q  <= '0;
    end else if (cmd_i.cap_rv) begin
      rv_q  <= ram_rdata;
    end
  end

  // Shift index
  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load) begin
      idx_q <= cmd_i.idx_from_tgt ? tgt_q : cnt_q;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - 1'b1;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Memory addressing
  always_comb begin
    case (cmd_i.ra_sel)
      ilir_pkg::RA_TGT:   ram_raddr = AW'(tgt_q);
      ilir_pkg::RA_BELOW: ram_raddr = AW'(idx_q - 1'b1);
      ilir_pkg::RA_ABOVE: ram_raddr = AW'(idx_q + 1'b1);
      default:            ram_raddr = AW'(tgt_q);
    endcase
  end

  assign ram_waddr = cmd_i.wa_idx ? AW'(idx_q) : AW'(tgt_q);
  assign ram_wdata = cmd_i.wd_mem ? ram_rdata : val_q;

  ilir_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status toward the controller
  assign stat_o.is_ins   = (act_q == ilir_pkg::ACT_INS_AT) ||
                           (act_q == ilir_pkg::ACT_INS_FRONT) ||
                           (act_q == ilir_pkg::ACT_INS_END);
  assign stat_o.is_clr   = act_q == ilir_pkg::ACT_CLEAR;
  assign stat_o.is_read  = act_q == ilir_pkg::ACT_READ;
  assign stat_o.is_rem   = act_q == ilir_pkg::ACT_REMOVE;
  assign stat_o.refused  = st_q != ilir_pkg::ST_OK;
  assign stat_o.ins_more = idx_q > tgt_q;
  assign stat_o.rem_more = ({1'b0, idx_q} + 1'b1) < {1'b0, cnt_q};

  // Result fields
  assign read_value_o = rv_q;
  assign status_o     = st_q;
  assign item_count_o = 5'(cnt_q);
  assign is_empty_o   = cnt_q == '0;

`ifndef NO_ASSERTIONS
  // Count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Count moves by one, or drops to zero on clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == '0 || cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1))
    else $error("entry count jumped");
`endif

endmodule

// ----- src/ilir_ctrl.sv -----
// Controller: sequences checks, entry shifts and result strobe for each request.
module ilir_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ilir_pkg::ilir_stat_t  stat_i,
  output ilir_pkg::ilir_cmd_t   cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_INS_CHK,
    S_INS_WR,
    S_CAP,
    S_REM_CHK,
    S_REM_WR
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  logic   finish;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    cmd_o   = '0;
    cmd_o.ra_sel = ilir_pkg::RA_TGT;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.refused) begin
          finish = 1'b1;
        end else if (stat_i.is_clr) begin
          cmd_o.cnt_clr = 1'b1;
          finish        = 1'b1;
        end else if (stat_i.is_ins) begin
          cmd_o.idx_load = 1'b1;
          state_d        = S_INS_CHK;
        end else if (stat_i.is_read || stat_i.is_rem) begin
          cmd_o.ram_re = 1'b1;
          state_d      = S_CAP;
        end else begin
          finish = 1'b1;
        end
      end
      // Move entries up from the end toward the target, then drop the value in
      S_INS_CHK: begin
        if (stat_i.ins_more) begin
          cmd_o.ram_re = 1'b1;
          cmd_o.ra_sel = ilir_pkg::RA_BELOW;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.ram_we  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          finish        = 1'b1;
        end
      end
      S_INS_WR: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wa_idx  = 1'b1;
        cmd_o.wd_mem  = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_INS_CHK;
      end
      S_CAP: begin
        cmd_o.cap_rv = 1'b1;
        if (stat_i.is_rem) begin
          cmd_o.idx_load     = 1'b1;
          cmd_o.idx_from_tgt = 1'b1;
          state_d            = S_REM_CHK;
        end else begin
          finish = 1'b1;
        end
      end
      // Move entries above the target down one place
      S_REM_CHK: begin
        if (stat_i.rem_more) begin
          cmd_o.ram_re = 1'b1;
          cmd_o.ra_sel = ilir_pkg::RA_ABOVE;
          state_d      = S_REM_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          finish        = 1'b1;
        end
      end
      S_REM_WR: begin
        cmd_o.ram_we  = 1'b1;
        cmd_o.wa_idx  = 1'b1;
        cmd_o.wd_mem  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_REM_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (finish) begin
      state_d = S_IDLE;
    end
  end

  assign busy_d = finish ? 1'b0 : (((state_q == S_IDLE) && start_i) ? 1'b1 : busy_q);
  assign done_d = finish;

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  // Memory is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_o.ram_we && cmd_o.ram_re))
    else $error("memory read and write collide");

  // A result strobe never overlaps a request in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start_i && !busy_o) |=> busy_o)
    else $error("request transfer did not set busy");
`endif

endmodule

// ----- src/indexed_list_insert_remove.sv -----
// Top level of the indexed list: ordered list of signed 32-bit entries with insert and remove.
//
// Request channel: a transfer takes place at a rising edge with start_i high and
// busy_o low; action_i, position_i and item_value_i are sampled there. busy_o
// stays high until the request has finished.
// Result channel: done_o pulses for one cycle with read_value_o, status_o,
// item_count_o and is_empty_o valid in that cycle. There is no back-pressure:
// the receiver must take the result in that cycle.
// Steps per request: clear, refused requests and unused codes finish in the
// evaluation state; a read reads the entry memory and captures the value; an
// insert moves the entries from the end down to the target up one place, then
// writes the new value; a remove reads and captures the entry, then moves the
// entries above it down one place. Each moved entry costs one memory read and
// one memory write. busy_o is low in the strobe cycle, so the next request may
// be transferred there; one request is in flight at a time.
// Reset clears the count (empty list) and the controller; entry contents are
// not cleared and only entries below the count are ever read.
module indexed_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o,
  output logic [4:0]         item_count_o,
  output logic               is_empty_o
);

  ilir_pkg::ilir_cmd_t  cmd;
  ilir_pkg::ilir_stat_t stat;

  ilir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ilir_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .is_empty_o   (is_empty_o)
  );

endmodule

// ----- bench/list_checker.sv -----
// Checker for the indexed list: watches both channels, predicts each result and compares.
module list_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         action_i,
  input  logic [4:0]         position_i,
  input  logic signed [31:0] item_value_i,
  input  logic               done_i,
  input  logic signed [31:0] read_value_i,
  input  logic [1:0]         status_i,
  input  logic [4:0]         item_count_i,
  input  logic               is_empty_i,
  output int                 err_count_o,
  output int                 outstanding_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [4:0]         count;
    logic               empty;
  } list_reply_t;

  // Shadow copy of the list contents and length
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_len;
  list_reply_t        pending_replies [$];
  int                 err_count;

  assign err_count_o = err_count;

  // Apply one request to the shadow list and return the reply it should produce
  function automatic list_reply_t apply_request(input logic [2:0]         act,
                                                input logic [4:0]         pos,
                                                input logic signed [31:0] val);
    list_reply_t r;
    bit          do_ins;
    int          at;
    int          i;
    r.value  = '0;
    r.status = ilir_pkg::ST_OK;
    do_ins   = 1'b0;
    at       = 0;
    case (act)
      ilir_pkg::ACT_INS_AT: begin
        // range test wins over the full test
        if (pos > shadow_len) r.status = ilir_pkg::ST_RANGE;
        else begin
          do_ins = 1'b1;
          at     = pos;
        end
      end
      ilir_pkg::ACT_INS_FRONT: begin
        do_ins = 1'b1;
        at     = 0;
      end
      ilir_pkg::ACT_INS_END: begin
        do_ins = 1'b1;
        at     = shadow_len;
      end
      ilir_pkg::ACT_READ: begin
        if (pos >= shadow_len) r.status = ilir_pkg::ST_RANGE;
        else r.value = shadow_list[pos];
      end
      ilir_pkg::ACT_REMOVE: begin
        if (pos >= shadow_len) r.status = ilir_pkg::ST_RANGE;
        else begin
          r.value = shadow_list[pos];
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
        end
      end
      ilir_pkg::ACT_CLEAR: begin
        for (i = 0; i < DEPTH; i++) shadow_list[i] = '0;
        shadow_len = 0;
      end
      default: ;  // spare codes leave the list alone
    endcase
    if (do_ins) begin
      if (shadow_len >= DEPTH) r.status = ilir_pkg::ST_FULL;
      else begin
        for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[at] = val;
        shadow_len++;
      end
    end
    r.count = shadow_len[4:0];
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  // Compare each result with the oldest prediction, then record the new request
  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      pending_replies.delete();
      err_count = 0;
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        if (pending_replies.size() == 0) begin
          $error("result transfer with no request outstanding");
          err_count++;
        end else begin
          want = pending_replies.pop_front();
          if (read_value_i !== want.value) begin
            $error("read_value: expected %0d, got %0d", want.value, read_value_i);
            err_count++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            err_count++;
          end
          if (item_count_i !== want.count) begin
            $error("item_count: expected %0d, got %0d", want.count, item_count_i);
            err_count++;
          end
          if (is_empty_i !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, is_empty_i);
            err_count++;
          end
        end
      end
      if (start_i && !busy_i)
        pending_replies.push_back(apply_request(action_i, position_i, item_value_i));
      outstanding_o <= pending_replies.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the indexed list: clock, reset, request stimulus, watchdog and verdict.
module tb_top;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 1350;
  localparam int CALM_TAIL   = 200;   // last requests sent with no idling
  localparam int PAUSE_AT    = 600;
  localparam int DRAIN_WAIT  = 40;    // longer than the slowest insert or remove
  localparam int QUIET_LIMIT = 2000;

  // Spare action codes, answered without any change
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         action;
  logic [4:0]         position;
  logic signed [31:0] item_value;
  logic               done;
  logic signed [31:0] read_value;
  logic [1:0]         status;
  logic [4:0]         item_count;
  logic               is_empty;
  int                 err_count;
  int                 outstanding;
  int                 quiet_cycles;
  int                 count_hint;
  bit                 idle_on;

  indexed_list_insert_remove #(.DEPTH(DEPTH)) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .action_i     (action),
    .position_i   (position),
    .item_value_i (item_value),
    .done_o       (done),
    .read_value_o (read_value),
    .status_o     (status),
    .item_count_o (item_count),
    .is_empty_o   (is_empty)
  );

  list_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .action_i      (action),
    .position_i    (position),
    .item_value_i  (item_value),
    .done_i        (done),
    .read_value_i  (read_value),
    .status_i      (status),
    .item_count_i  (item_count),
    .is_empty_i    (is_empty),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Last reported fill level, used only to steer positions toward valid indexes
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) count_hint <= 0;
    else if (done) count_hint <= item_count;
  end

  // Cycles since the last transfer on either channel
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) quiet_cycles <= 0;
    else if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // Drive one request and hold it until the block takes it
  task automatic post_request(input logic [2:0] act, input logic [4:0] pos,
                              input logic [31:0] val);
    start      <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
  endtask

  // Occasional idle burst of random length on the request side
  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every predicted result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly from 0 to the last reported fill level, sometimes anywhere from 0 to 16
  function automatic logic [4:0] pick_position();
    if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(0, (count_hint < 16) ? count_hint : 16));
  endfunction

  // Grow phases favor inserts, shrink phases favor removes
  function automatic logic [2:0] pick_action(input bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 25) return ilir_pkg::ACT_INS_AT;
      if (r < 40) return ilir_pkg::ACT_INS_FRONT;
      if (r < 58) return ilir_pkg::ACT_INS_END;
      if (r < 78) return ilir_pkg::ACT_READ;
      if (r < 97) return ilir_pkg::ACT_REMOVE;
      if (r < 98) return ilir_pkg::ACT_CLEAR;
    end else begin
      if (r < 8)  return ilir_pkg::ACT_INS_AT;
      if (r < 13) return ilir_pkg::ACT_INS_FRONT;
      if (r < 18) return ilir_pkg::ACT_INS_END;
      if (r < 40) return ilir_pkg::ACT_READ;
      if (r < 96) return ilir_pkg::ACT_REMOVE;
      if (r < 98) return ilir_pkg::ACT_CLEAR;
    end
    return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
  endfunction

  initial begin
    int         fill;
    int         sent;
    int         phase_left;
    bit         grow;
    logic [2:0] act;

    rst_n      = 1'b0;
    start      = 1'b0;
    action     = ilir_pkg::ACT_READ;
    position   = '0;
    item_value = '0;
    idle_on    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: refusals on the empty list and the spare codes
    post_request(ilir_pkg::ACT_READ, 5'd0, 32'h0);
    post_request(ilir_pkg::ACT_REMOVE, 5'd0, 32'h0);
    post_request(ilir_pkg::ACT_INS_AT, 5'd1, 32'h1234_5678);
    post_request(ACT_SPARE_LO, 5'd0, 32'h0);
    post_request(ACT_SPARE_HI, 5'd16, 32'hFFFF_FFFF);

    // Directed: fill to capacity with value extremes and every insert kind
    post_request(ilir_pkg::ACT_INS_FRONT, 5'd0, 32'h7FFF_FFFF);
    post_request(ilir_pkg::ACT_INS_END, 5'd0, 32'h8000_0000);
    post_request(ilir_pkg::ACT_INS_AT, 5'd1, 32'hFFFF_FFFF);
    for (fill = 3; fill < DEPTH; fill++)
      post_request(ilir_pkg::ACT_INS_AT, 5'($urandom_range(0, fill)), $urandom());

    // Directed: every insert refused as full, then edge reads and removes, and a clear
    post_request(ilir_pkg::ACT_INS_AT, 5'd16, 32'h0);
    post_request(ilir_pkg::ACT_INS_FRONT, 5'd0, 32'h1);
    post_request(ilir_pkg::ACT_INS_END, 5'd0, 32'h2);
    post_request(ilir_pkg::ACT_READ, 5'd15, 32'h0);
    post_request(ilir_pkg::ACT_READ, 5'd16, 32'h0);
    post_request(ilir_pkg::ACT_REMOVE, 5'd0, 32'h0);
    post_request(ilir_pkg::ACT_REMOVE, 5'd14, 32'h0);
    post_request(ilir_pkg::ACT_CLEAR, 5'd0, 32'h0);

    // Random part in grow and shrink phases so the fill level sweeps end to end
    sent       = 0;
    phase_left = 0;
    grow       = 1'b1;
    while (sent < RANDOM_REQS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        grow       = !grow;
        idle_on    = $urandom_range(0, 2) != 0;
      end
      phase_left--;
      if (sent >= RANDOM_REQS - CALM_TAIL) idle_on = 1'b0;
      if (sent == PAUSE_AT) wait_drained();
      idle_burst();
      act = pick_action(grow);
      post_request(act, pick_position(), pick_value());
      if (act <= ilir_pkg::ACT_CLEAR) sent++;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
